### rtl/assert_macros.svh
// assertion helpers, clocked on clk_i
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define HLVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define HLVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/hlva_pkg.sv
`default_nettype none

package hlva_pkg;

  localparam int THETA_BINS  = 180;
  localparam int IMG_WIDTH   = 512;
  localparam int IMG_HEIGHT  = 512;
  localparam int THETA_AW    = $clog2(THETA_BINS);

  localparam int COORD_W     = 9;
  localparam int VALUE_W     = 8;
  localparam int RHO_IDX_W   = 11;
  localparam int THETA_IDX_W = 8;
  localparam int COUNT_W     = 19;
  localparam int POINT_W     = 2 * COORD_W;
  localparam int TRIG_W      = 18;
  localparam int WORD_W      = COUNT_W + 2 * POINT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [VALUE_W-1:0] EDGE_VALUE = 8'd255;

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic {
    OP_VOTE = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    op_e                    operation;
    logic [COORD_W-1:0]     pixel_x;
    logic [COORD_W-1:0]     pixel_y;
    logic [VALUE_W-1:0]     pixel_value;
    logic [RHO_IDX_W-1:0]   rho_index;
    logic [THETA_IDX_W-1:0] theta_index;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] vote_count;
    logic               has_points;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] last_x;
    logic [COORD_W-1:0] last_y;
  } out_item_t;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef trig_t [THETA_BINS-1:0]   trig_tab_t;

  // horner-form taylor sine in q2.30, x in [0, pi/2]
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] u;
    logic [63:0] t;
    int          i;
    x2 = (x * x) >> 30;
    r  = ONE_Q30;
    for (i = 0; i < 6; i++) begin
      u = (x2 * r) >> 30;
      case (i)
        0:       t = u / 64'd156;
        1:       t = u / 64'd110;
        2:       t = u / 64'd72;
        3:       t = u / 64'd42;
        4:       t = u / 64'd20;
        default: t = u / 64'd6;
      endcase
      r = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    end
    return (x * r) >> 30;
  endfunction

  function automatic trig_t q30_to_q16(input logic [63:0] v);
    logic [63:0] s;
    s = (v + 64'd8192) >> 14;
    return trig_t'(s[TRIG_W-1:0]);
  endfunction

  function automatic logic is_upper(input int m);
    return (2 * m) > THETA_BINS;
  endfunction

  // bin angle folded into [0, pi/2]
  function automatic logic [63:0] angle_q30(input int m);
    logic [63:0] k;
    logic [63:0] x;
    k = is_upper(m) ? 64'(THETA_BINS - m) : 64'(m);
    x = (PI_Q30 / THETA_BINS) * k + ((PI_Q30 % THETA_BINS) * k) / THETA_BINS;
    return (x > HALF_PI_Q30) ? HALF_PI_Q30 : x;
  endfunction

  function automatic trig_tab_t build_sin_tab();
    trig_tab_t tab;
    int        m;
    for (m = 0; m < THETA_BINS; m++) begin
      tab[m] = q30_to_q16(sin_q30(angle_q30(m)));
    end
    return tab;
  endfunction

  function automatic trig_tab_t build_cos_tab();
    trig_tab_t tab;
    trig_t     c;
    int        m;
    for (m = 0; m < THETA_BINS; m++) begin
      c      = q30_to_q16(sin_q30(HALF_PI_Q30 - angle_q30(m)));
      tab[m] = is_upper(m) ? trig_t'(-c) : c;
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

### rtl/hough_line_vote_accumulator.sv
// Hough line vote accumulator. A vote item whose pixel value is 255 and that lies inside
// the image casts one vote in every angle bin whose rho bin lies inside the store: the rho
// unit works through the bins one per cycle and each vote is a read-modify-write of one
// cell over the store's read port and write port, so such an item keeps the block busy
// until its last vote is written. Other vote items and out-of-range reads go straight to
// the push state, a cell read first passes through the read and read-data states, and every
// item then waits in the push state for the output register to free. After reset the store
// is cleared one cell per cycle, all THETA_BINS * RHO_BINS cells, before the first item is accepted.
// Vote items and out-of-range reads return an all-zero result; a read returns the cell's
// count and its first and latest voting pixel.
`default_nettype none
`include "assert_macros.svh"

module hough_line_vote_accumulator #(
  parameter int RHO_BINS = 1449
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire hlva_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output hlva_pkg::out_item_t      out_item_o
);

  localparam int Depth  = hlva_pkg::THETA_BINS * RHO_BINS;
  localparam int CellAw = $clog2(Depth);
  localparam int MW     = $clog2(hlva_pkg::THETA_BINS + 1);
  localparam int WordW  = hlva_pkg::WORD_W;
  localparam int PtW    = hlva_pkg::POINT_W;
  localparam int CW     = hlva_pkg::COORD_W;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_VOTE  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_RDATA = 6'b010000,
    ST_PUSH  = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  logic [CellAw-1:0]             clr_q, clr_d;
  logic [MW-1:0]                 m_q, m_d;
  logic [CW-1:0]                 px_q;
  logic [CW-1:0]                 py_q;
  logic [CellAw-1:0]             rd_cell_q;
  logic                          val3_q;
  logic [CellAw-1:0]             cell3_q;
  hlva_pkg::out_item_t           res_q, res_d;
  logic                          out_valid_q;
  hlva_pkg::out_item_t           out_q;

  logic                          in_fire;
  logic                          votes_ok;
  logic                          read_ok;
  logic [CellAw-1:0]             in_cell;
  logic                          issue;
  logic                          vote_done;
  logic                          push;
  logic                          rho_valid;
  logic                          rho_busy;
  logic [CellAw-1:0]             rho_cell;
  logic                          mem_we;
  logic [CellAw-1:0]             mem_waddr;
  logic [WordW-1:0]              mem_wdata;
  logic                          mem_re;
  logic [CellAw-1:0]             mem_raddr;
  logic [WordW-1:0]              mem_rdata;
  logic [hlva_pkg::COUNT_W-1:0]  old_cnt;
  logic [PtW-1:0]                old_first;
  logic [PtW-1:0]                old_last;
  logic [hlva_pkg::COUNT_W-1:0]  new_cnt;
  logic [PtW-1:0]                new_first;
  logic [PtW-1:0]                cur_pt;

  assign in_stall_o = !rst_ni || (state_q != ST_IDLE);
  assign in_fire    = in_valid_i & ~in_stall_o;

  assign votes_ok = (in_item_i.pixel_value == hlva_pkg::EDGE_VALUE)
                 && (32'(in_item_i.pixel_x) < hlva_pkg::IMG_WIDTH)
                 && (32'(in_item_i.pixel_y) < hlva_pkg::IMG_HEIGHT);
  assign read_ok  = (32'(in_item_i.rho_index) < RHO_BINS)
                 && (32'(in_item_i.theta_index) < hlva_pkg::THETA_BINS);
  assign in_cell  = CellAw'(in_item_i.rho_index) * CellAw'(hlva_pkg::THETA_BINS)
                  + CellAw'(in_item_i.theta_index);

  assign issue     = (state_q == ST_VOTE) && (m_q < MW'(hlva_pkg::THETA_BINS));
  assign vote_done = (state_q == ST_VOTE) && !issue && !rho_busy && !val3_q;
  assign push      = (state_q == ST_PUSH) && (!out_valid_q || !out_stall_i);

  hlva_rho_unit #(
    .RHO_BINS (RHO_BINS)
  ) u_rho (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .theta_i   (m_q[hlva_pkg::THETA_AW-1:0]),
    .pixel_x_i (px_q),
    .pixel_y_i (py_q),
    .valid_o   (rho_valid),
    .busy_o    (rho_busy),
    .cell_o    (rho_cell)
  );

  // cell word: count, first point, last point
  assign old_cnt   = mem_rdata[WordW-1 -: hlva_pkg::COUNT_W];
  assign old_first = mem_rdata[2*PtW-1 -: PtW];
  assign old_last  = mem_rdata[PtW-1:0];
  assign cur_pt    = {py_q, px_q};
  assign new_cnt   = (old_cnt != hlva_pkg::COUNT_MAX) ? old_cnt + hlva_pkg::COUNT_W'(1)
                                                      : old_cnt;
  assign new_first = (old_cnt == '0) ? cur_pt : old_first;

  assign mem_re    = rho_valid | (state_q == ST_READ);
  assign mem_raddr = (state_q == ST_READ) ? rd_cell_q : rho_cell;
  assign mem_we    = (state_q == ST_CLEAR) | val3_q;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : cell3_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : {new_cnt, new_first, cur_pt};

  hlva_store #(
    .DEPTH (Depth),
    .WIDTH (WordW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    m_d     = m_q;
    res_d   = res_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + CellAw'(1);
        if (clr_q == CellAw'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          res_d = '0;
          if (in_item_i.operation == hlva_pkg::OP_READ) begin
            state_d = read_ok ? ST_READ : ST_PUSH;
          end else if (votes_ok) begin
            state_d = ST_VOTE;
            m_d     = '0;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_VOTE: begin
        if (issue) begin
          m_d = m_q + MW'(1);
        end
        if (vote_done) begin
          state_d = ST_PUSH;
        end
      end
      ST_READ: begin
        state_d = ST_RDATA;
      end
      ST_RDATA: begin
        res_d.vote_count = old_cnt;
        res_d.has_points = (old_cnt != '0);
        if (old_cnt != '0) begin
          res_d.first_x = old_first[CW-1:0];
          res_d.first_y = old_first[PtW-1:CW];
          res_d.last_x  = old_last[CW-1:0];
          res_d.last_y  = old_last[PtW-1:CW];
        end
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (push) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      m_q         <= '0;
      val3_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      m_q         <= m_d;
      val3_q      <= rho_valid;
      out_valid_q <= push | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_q      <= in_item_i.pixel_x;
      py_q      <= in_item_i.pixel_y;
      rd_cell_q <= in_cell;
    end
    cell3_q <= rho_cell;
    res_q   <= res_d;
    if (push) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `HLVA_ASSERT(a_accept_leaves_idle, in_fire |=> state_q != ST_IDLE, "item accepted but idle")
  `HLVA_ASSERT(a_cell_write_in_vote, val3_q |-> state_q == ST_VOTE, "cell write outside vote")
  `HLVA_ASSERT(a_out_from_push, $rose(out_valid_q) |-> $past(state_q == ST_PUSH), "stray result")
  `HLVA_ASSERT_ALWAYS(a_stall_in_reset, !rst_ni |-> in_stall_o, "input open during reset")

endmodule

`default_nettype wire

### rtl/hlva_store.sv
`default_nettype none

module hlva_store #(
  parameter int DEPTH = 260820,
  parameter int WIDTH = 55
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/hlva_rho_unit.sv
`default_nettype none

module hlva_rho_unit #(
  parameter int RHO_BINS = 1449
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         issue_i,
  input  wire logic [hlva_pkg::THETA_AW-1:0]                theta_i,
  input  wire logic [hlva_pkg::COORD_W-1:0]                 pixel_x_i,
  input  wire logic [hlva_pkg::COORD_W-1:0]                 pixel_y_i,
  output logic                                              valid_o,
  output logic                                              busy_o,
  output logic [$clog2(hlva_pkg::THETA_BINS*RHO_BINS)-1:0] cell_o
);

  localparam int Depth  = hlva_pkg::THETA_BINS * RHO_BINS;
  localparam int CellAw = $clog2(Depth);
  localparam logic signed [31:0] RhoOfs = 32'((RHO_BINS - 1) / 2 * 65536 + 32768);
  localparam hlva_pkg::trig_tab_t SinTab = hlva_pkg::build_sin_tab();
  localparam hlva_pkg::trig_tab_t CosTab = hlva_pkg::build_cos_tab();

  logic                               val1_q;
  logic signed [27:0]                 pc_q;
  logic signed [27:0]                 ps_q;
  logic [hlva_pkg::THETA_AW-1:0]      th1_q;
  logic                               val2_q;
  logic [hlva_pkg::RHO_IDX_W-1:0]     n2_q;
  logic [hlva_pkg::THETA_AW-1:0]      th2_q;
  logic signed [31:0]                 rho_sum;
  logic                               rho_ok;

  // x*cos and y*sin in q16
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val1_q <= 1'b0;
      val2_q <= 1'b0;
    end else begin
      val1_q <= issue_i;
      val2_q <= val1_q & rho_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      pc_q  <= 28'($signed({1'b0, pixel_x_i})) * 28'(CosTab[theta_i]);
      ps_q  <= 28'($signed({1'b0, pixel_y_i})) * 28'(SinTab[theta_i]);
      th1_q <= theta_i;
    end
  end

  // offset and round half up, then bin range check
  assign rho_sum = 32'(pc_q) + 32'(ps_q) + RhoOfs;
  assign rho_ok  = !rho_sum[31] && (32'(rho_sum[31:16]) < RHO_BINS);

  always_ff @(posedge clk_i) begin
    if (val1_q) begin
      n2_q  <= rho_sum[16 +: hlva_pkg::RHO_IDX_W];
      th2_q <= th1_q;
    end
  end

  assign valid_o = val2_q;
  assign busy_o  = val1_q | val2_q;
  assign cell_o  = CellAw'(n2_q) * CellAw'(hlva_pkg::THETA_BINS) + CellAw'(th2_q);

endmodule

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RHO_BINS       = 1449;
  localparam int RHO_CENTER     = (RHO_BINS - 1) / 2;
  localparam int FULL_EDGE      = 255;
  localparam int COUNT_SAT      = (1 << hlva_pkg::COUNT_W) - 1;
  localparam int WATCHDOG_LIMIT = 800000;
  localparam int ITEM_TARGET    = 900;
  localparam int REPORT_LIMIT   = 10;
  localparam int DRAIN_CYCLES   = 200;
  localparam int POOL_DEPTH     = 256;
  localparam int TB_THETA       = hlva_pkg::THETA_BINS;
  localparam int CW             = hlva_pkg::COORD_W;
  localparam int PW             = hlva_pkg::POINT_W;

  class vote_tracker;
    int                      cos_q16 [TB_THETA];
    int                      sin_q16 [TB_THETA];
    int unsigned             votes [int];
    logic [PW-1:0]           first_pt [int];
    logic [PW-1:0]           last_pt [int];
    hlva_pkg::out_item_t     expected_q [$];
    int                      errors;

    function new();
      longint unsigned pi_q30;
      longint unsigned half_pi;
      longint unsigned ang;
      longint unsigned k;
      bit              upper;
      int              c;
      pi_q30  = 64'd3373259426;
      half_pi = 64'd1686629713;
      errors  = 0;
      for (int m = 0; m < TB_THETA; m++) begin
        upper = (2 * m) > TB_THETA;
        k     = upper ? longint'(TB_THETA - m) : longint'(m);
        ang   = (pi_q30 / TB_THETA) * k + ((pi_q30 % TB_THETA) * k) / TB_THETA;
        if (ang > half_pi) ang = half_pi;
        sin_q16[m] = to_q16(taylor_sin(ang));
        c          = to_q16(taylor_sin(half_pi - ang));
        cos_q16[m] = upper ? -c : c;
      end
    endfunction

    // q2.30 sine by truncated taylor series, argument in [0, pi/2]
    function longint unsigned taylor_sin(longint unsigned x);
      longint unsigned one;
      longint unsigned x2;
      longint unsigned r;
      longint unsigned t;
      longint unsigned divs [6];
      one  = 64'd1 << 30;
      divs = '{156, 110, 72, 42, 20, 6};
      x2   = (x * x) >> 30;
      r    = one;
      for (int i = 0; i < 6; i++) begin
        t = ((x2 * r) >> 30) / divs[i];
        r = (t > one) ? 64'd0 : one - t;
      end
      return (x * r) >> 30;
    endfunction

    function int to_q16(longint unsigned v);
      return int'((v + 64'd8192) >> 14);
    endfunction

    // rho bin of a pixel in angle bin m, -1 when it falls outside the store
    function int rho_bin(int x, int y, int m);
      longint acc;
      acc = longint'(x) * cos_q16[m] + longint'(y) * sin_q16[m]
          + longint'(RHO_CENTER) * 65536 + 32768;
      if (acc < 0) return -1;
      acc = acc >>> 16;
      if (acc >= RHO_BINS) return -1;
      return int'(acc);
    endfunction

    function string describe(hlva_pkg::out_item_t o);
      return $sformatf("count=%0d has=%0b first=(%0d,%0d) last=(%0d,%0d)",
                       o.vote_count, o.has_points, o.first_x, o.first_y,
                       o.last_x, o.last_y);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function void note_item(hlva_pkg::in_item_t it);
      hlva_pkg::out_item_t exp;
      logic [PW-1:0]       pt;
      int                  n;
      int                  cell_idx;
      int unsigned         cnt;
      exp = '0;
      if (it.operation == hlva_pkg::OP_VOTE) begin
        pt = {it.pixel_y, it.pixel_x};
        if (it.pixel_value == FULL_EDGE && it.pixel_x < hlva_pkg::IMG_WIDTH &&
            it.pixel_y < hlva_pkg::IMG_HEIGHT) begin
          for (int m = 0; m < TB_THETA; m++) begin
            n = rho_bin(it.pixel_x, it.pixel_y, m);
            if (n >= 0) begin
              cell_idx = n * TB_THETA + m;
              cnt      = votes.exists(cell_idx) ? votes[cell_idx] : 0;
              if (cnt == 0) first_pt[cell_idx] = pt;
              if (cnt < COUNT_SAT) votes[cell_idx] = cnt + 1;
              last_pt[cell_idx] = pt;
            end
          end
        end
      end else if (it.rho_index < RHO_BINS && it.theta_index < TB_THETA) begin
        cell_idx = int'(it.rho_index) * TB_THETA + int'(it.theta_index);
        if (votes.exists(cell_idx) && votes[cell_idx] != 0) begin
          cnt            = votes[cell_idx];
          exp.vote_count = cnt[hlva_pkg::COUNT_W-1:0];
          exp.has_points = 1'b1;
          pt             = first_pt[cell_idx];
          exp.first_x    = pt[CW-1:0];
          exp.first_y    = pt[PW-1:CW];
          pt             = last_pt[cell_idx];
          exp.last_x     = pt[CW-1:0];
          exp.last_y     = pt[PW-1:CW];
        end
      end
      expected_q.insert(expected_q.size(), exp);
    endfunction

    function void check_result(hlva_pkg::out_item_t got);
      hlva_pkg::out_item_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result: %s", describe(got)));
      end else begin
        exp = expected_q.pop_front();
        if (got.vote_count !== exp.vote_count || got.has_points !== exp.has_points ||
            got.first_x !== exp.first_x || got.first_y !== exp.first_y ||
            got.last_x !== exp.last_x || got.last_y !== exp.last_y) begin
          report($sformatf("mismatch: expected %s, got %s", describe(exp), describe(got)));
        end
      end
    endfunction
  endclass

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  hlva_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  hlva_pkg::out_item_t out_item;

  vote_tracker        tracker;
  bit                 send_quiet;
  bit                 recv_quiet;
  int                 stall_left;
  int                 idle_cycles;
  logic [PW-1:0]      voted_pts [$];
  int                 line_x;
  int                 line_y;
  int                 line_dx;
  int                 line_dy;

  hough_line_vote_accumulator #(
    .RHO_BINS(RHO_BINS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic hlva_pkg::in_item_t random_fill();
    logic [63:0]        bits;
    hlva_pkg::in_item_t it;
    bits = {$urandom, $urandom};
    it   = bits[$bits(hlva_pkg::in_item_t)-1:0];
    return it;
  endfunction

  function automatic hlva_pkg::in_item_t vote_item(int x, int y, int v);
    hlva_pkg::in_item_t it;
    it             = random_fill();
    it.operation   = hlva_pkg::OP_VOTE;
    it.pixel_x     = x[CW-1:0];
    it.pixel_y     = y[CW-1:0];
    it.pixel_value = v[hlva_pkg::VALUE_W-1:0];
    return it;
  endfunction

  function automatic hlva_pkg::in_item_t read_item(int r, int t);
    hlva_pkg::in_item_t it;
    it             = random_fill();
    it.operation   = hlva_pkg::OP_READ;
    it.rho_index   = r[hlva_pkg::RHO_IDX_W-1:0];
    it.theta_index = t[hlva_pkg::THETA_IDX_W-1:0];
    return it;
  endfunction

  // read the cell that pixel (x,y) votes for in angle bin m
  function automatic hlva_pkg::in_item_t cell_read(int x, int y, int m);
    int n;
    n = tracker.rho_bin(x, y, m);
    return read_item((n < 0) ? 0 : n, m);
  endfunction

  task automatic send_item(input hlva_pkg::in_item_t it);
    int gap;
    gap = send_quiet ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (!(in_valid && !in_stall)) @(posedge clk_i);
  endtask

  task automatic send_vote(input int x, input int y);
    send_item(vote_item(x, y, FULL_EDGE));
    voted_pts.insert(voted_pts.size(), {y[CW-1:0], x[CW-1:0]});
    if (voted_pts.size() > POOL_DEPTH) void'(voted_pts.pop_front());
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = recv_quiet ? 0 : idle_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) tracker.note_item(in_item);
      if (out_valid && !out_stall) tracker.check_result(out_item);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int            counted;
    int            roll;
    int            pick;
    int            x;
    int            y;
    logic [PW-1:0] pt;
    tracker    = new();
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    line_x = 0;
    line_y = 0;
    line_dx = 1;
    line_dy = 2;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty store, out-of-range reads, non-edge pixels
    send_item(read_item(0, 0));
    send_item(read_item(RHO_BINS - 1, TB_THETA - 1));
    send_item(read_item(RHO_BINS, 0));
    send_item(read_item(0, TB_THETA));
    send_item(read_item(2047, 255));
    send_item(vote_item(0, 0, 254));
    send_item(vote_item(511, 511, 0));
    // corner pixels and a shared cell with distinct first and last point
    send_vote(0, 0);
    send_item(cell_read(0, 0, 0));
    send_vote(511, 511);
    send_vote(511, 0);
    send_vote(0, 511);
    send_vote(5, 10);
    send_vote(5, 300);
    send_item(cell_read(5, 10, 0));
    send_item(cell_read(511, 511, 45));
    send_item(cell_read(511, 0, TB_THETA - 1));
    send_item(cell_read(0, 511, 90));
    send_vote(0, 0);
    send_item(read_item(RHO_CENTER, 90));
    send_item(read_item(RHO_CENTER, TB_THETA - 1));

    counted = 0;
    while (counted < ITEM_TARGET) begin
      if (counted % 60 == 0) begin
        send_quiet = ($urandom_range(0, 3) == 0);
        recv_quiet = ($urandom_range(0, 3) == 0);
        line_x  = $urandom_range(0, 511);
        line_y  = $urandom_range(0, 511);
        line_dx = $urandom_range(0, 6);
        line_dy = $urandom_range(0, 6);
      end
      counted++;
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        send_item(vote_item($urandom_range(0, 511), $urandom_range(0, 511),
                            $urandom_range(0, FULL_EDGE - 1)));
      end else if (roll < 48) begin
        pick = $urandom_range(0, 9);
        if (pick < 4 || voted_pts.size() == 0) begin
          x = $urandom_range(0, 511);
          y = $urandom_range(0, 511);
        end else if (pick < 8) begin
          line_x = (line_x + line_dx) % hlva_pkg::IMG_WIDTH;
          line_y = (line_y + line_dy) % hlva_pkg::IMG_HEIGHT;
          x = line_x;
          y = line_y;
        end else begin
          pt = voted_pts[$urandom_range(0, voted_pts.size() - 1)];
          x = pt[CW-1:0];
          y = pt[PW-1:CW];
        end
        send_vote(x, y);
      end else if (roll < 90 && voted_pts.size() != 0) begin
        pt = voted_pts[$urandom_range(0, voted_pts.size() - 1)];
        send_item(cell_read(pt[CW-1:0], pt[PW-1:CW],
                            $urandom_range(0, TB_THETA - 1)));
      end else begin
        send_item(read_item($urandom_range(0, 2047), $urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;
    @(posedge clk_i);

    while (tracker.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl
rtl/hlva_pkg.sv
rtl/hlva_store.sv
rtl/hlva_rho_unit.sv
rtl/hough_line_vote_accumulator.sv
tb/testbench.sv
